// ----- rtl/iphv_pkg.sv -----
// Shared types and constants for the IP header validator.
package iphv_pkg;

	// One received byte of the packet
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} rx_item_t;

	// Verdict given on the last byte of a packet
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  ip_version;
		logic [7:0]  protocol;
		logic [15:0] payload_bytes;
		logic [15:0] padding_length;
		logic [20:0] pseudo_sum;
	} result_item_t;

	// Status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_BAD_VERSION  = 3'd1;
	localparam logic [2:0] ST_SHORT_HEADER = 3'd2;
	localparam logic [2:0] ST_BAD_IHL      = 3'd3;
	localparam logic [2:0] ST_BAD_CHECKSUM = 3'd4;
	localparam logic [2:0] ST_FRAGMENT     = 3'd5;
	localparam logic [2:0] ST_TRUNCATED    = 3'd6;
	localparam logic [2:0] ST_BAD_PROTOCOL = 3'd7;

	// Header constants
	localparam logic [3:0]  VER_V4       = 4'd4;
	localparam logic [3:0]  VER_V6       = 4'd6;
	localparam logic [7:0]  V4_FIRST     = 8'h45;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;
	localparam logic [16:0] CNT_MAX      = 17'h1FFFF;
	localparam logic [16:0] V4_HDR_LEN   = 17'd20;
	localparam logic [16:0] V6_HDR_LEN   = 17'd40;
	localparam logic [15:0] V4_HDR_LEN16 = 16'd20;
	localparam logic [15:0] CSUM_GOOD    = 16'hFFFF;
	localparam logic [16:0] POS_TOT_LEN  = 17'd3;
	localparam logic [16:0] POS_V6_PLEN  = 17'd5;
	localparam logic [16:0] POS_FLAGS    = 17'd6;
	localparam logic [16:0] POS_V6_NEXT  = 17'd6;
	localparam logic [16:0] POS_V4_PROTO = 17'd9;
	localparam logic [16:0] POS_V4_ADDR  = 17'd12;
	localparam logic [16:0] POS_V6_ADDR  = 17'd8;
	// more-fragments bit 0x2000 of the flags word sits at bit 5 of its high byte
	localparam int          MF_BIT       = 5;

endpackage

// ----- rtl/iphv_core.sv -----
// Per-packet header state, byte absorption and end-of-packet verdict.
module iphv_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  iphv_pkg::rx_item_t    item,
	output iphv_pkg::result_item_t result
);
	import iphv_pkg::*;

	logic [16:0] byte_count_q, byte_count_d;
	logic [7:0]  first_byte_q, first_byte_d;
	logic [7:0]  high_byte_hold_q, high_byte_hold_d;
	logic [16:0] header_csum_q, header_csum_d;
	logic [20:0] address_sum_q, address_sum_d;
	logic [15:0] declared_length_q, declared_length_d;
	logic        more_fragments_q, more_fragments_d;
	logic [7:0]  proto_field_q, proto_field_d;

	logic [3:0]  ver;
	logic        odd;
	logic [15:0] word;
	logic [17:0] csum_sum;
	logic [16:0] n;
	logic [16:0] body;

	// Absorb the current byte into the header state
	always_comb begin
		first_byte_d      = first_byte_q;
		high_byte_hold_d  = high_byte_hold_q;
		header_csum_d     = header_csum_q;
		address_sum_d     = address_sum_q;
		declared_length_d = declared_length_q;
		more_fragments_d  = more_fragments_q;
		proto_field_d     = proto_field_q;
		csum_sum          = '0;

		if (byte_count_q == '0) begin
			first_byte_d = item.data_byte;
		end
		ver  = first_byte_d[7:4];
		odd  = byte_count_q[0];
		word = {high_byte_hold_q, item.data_byte};

		if (byte_count_q < V6_HDR_LEN) begin
			if (!odd) begin
				high_byte_hold_d = item.data_byte;
			end
			if (ver == VER_V4) begin
				if (byte_count_q < V4_HDR_LEN) begin
					if (odd) begin
						csum_sum      = {1'b0, header_csum_q} + {2'b00, word};
						header_csum_d = {1'b0, csum_sum[15:0]} + {15'd0, csum_sum[17:16]};
					end
					if (byte_count_q == POS_TOT_LEN) begin
						declared_length_d = word;
					end
					if (byte_count_q == POS_FLAGS) begin
						more_fragments_d = item.data_byte[MF_BIT];
					end
					if (byte_count_q == POS_V4_PROTO) begin
						proto_field_d = item.data_byte;
					end
					if (odd && byte_count_q >= POS_V4_ADDR) begin
						address_sum_d = address_sum_q + {5'd0, word};
					end
				end
			end else if (ver == VER_V6) begin
				if (byte_count_q == POS_V6_PLEN) begin
					declared_length_d = word;
				end
				if (byte_count_q == POS_V6_NEXT) begin
					proto_field_d = item.data_byte;
				end
				if (odd && byte_count_q >= POS_V6_ADDR) begin
					address_sum_d = address_sum_q + {5'd0, word};
				end
			end
		end

		// Advance the saturating byte count
		byte_count_d = (byte_count_q == CNT_MAX) ? byte_count_q : byte_count_q + 17'd1;
		n            = byte_count_d;
	end

	// Judge the packet from the updated state
	always_comb begin
		result.status         = ST_OK;
		result.ip_version     = ver;
		result.protocol       = proto_field_d;
		result.payload_bytes  = '0;
		result.padding_length = '0;
		result.pseudo_sum     = '0;
		body                  = '0;

		if (ver == VER_V4) begin
			if (n < V4_HDR_LEN) begin
				result.status = ST_SHORT_HEADER;
			end else if (first_byte_d != V4_FIRST) begin
				result.status = ST_BAD_IHL;
			end else if (header_csum_d != {1'b0, CSUM_GOOD}) begin
				result.status = ST_BAD_CHECKSUM;
			end else if (more_fragments_d) begin
				result.status = ST_FRAGMENT;
			end else if (declared_length_d < V4_HDR_LEN16 || n < {1'b0, declared_length_d}) begin
				result.status = ST_TRUNCATED;
			end else if (proto_field_d != PROTO_ICMP && proto_field_d != PROTO_UDP) begin
				result.status = ST_BAD_PROTOCOL;
			end else begin
				result.payload_bytes = declared_length_d - V4_HDR_LEN16;
				body                 = n - {1'b0, declared_length_d};
			end
		end else if (ver == VER_V6) begin
			if (n < V6_HDR_LEN) begin
				result.status = ST_SHORT_HEADER;
			end else if ((n - V6_HDR_LEN) < {1'b0, declared_length_d}) begin
				result.status = ST_TRUNCATED;
			end else if (proto_field_d != PROTO_ICMPV6) begin
				result.status = ST_BAD_PROTOCOL;
			end else begin
				result.payload_bytes = declared_length_d;
				body                 = n - V6_HDR_LEN - {1'b0, declared_length_d};
			end
		end else begin
			result.status = ST_BAD_VERSION;
		end

		if (result.status == ST_OK) begin
			result.padding_length = (body > 17'h0FFFF) ? 16'hFFFF : body[15:0];
			result.pseudo_sum     = address_sum_d + {13'd0, proto_field_d};
		end
	end

	// Hold state between bytes; drop it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= '0;
			first_byte_q      <= '0;
			high_byte_hold_q  <= '0;
			header_csum_q     <= '0;
			address_sum_q     <= '0;
			declared_length_q <= '0;
			more_fragments_q  <= 1'b0;
			proto_field_q     <= '0;
		end else if (en) begin
			if (item.last_byte) begin
				byte_count_q      <= '0;
				first_byte_q      <= '0;
				high_byte_hold_q  <= '0;
				header_csum_q     <= '0;
				address_sum_q     <= '0;
				declared_length_q <= '0;
				more_fragments_q  <= 1'b0;
				proto_field_q     <= '0;
			end else begin
				byte_count_q      <= byte_count_d;
				first_byte_q      <= first_byte_d;
				high_byte_hold_q  <= high_byte_hold_d;
				header_csum_q     <= header_csum_d;
				address_sum_q     <= address_sum_d;
				declared_length_q <= declared_length_d;
				more_fragments_q  <= more_fragments_d;
				proto_field_q     <= proto_field_d;
			end
		end
	end

endmodule

// ----- rtl/ip_header_validator.sv -----
// IP header validator top level: input register, header core, result register.
// Takes one byte transaction per cycle, sustained, while the result side is not stalled.
// A result is registered as its last byte passes from the input register into the core.
// Bytes that are not the last of a packet never wait on the result side.
// Reset (arst_n low) empties both registers and returns the header state to zero.
module ip_header_validator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rx_valid,
	output logic                   rx_stall,
	input  iphv_pkg::rx_item_t     rx_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output iphv_pkg::result_item_t result_item
);
	import iphv_pkg::*;

	logic         rx_valid_s1;
	rx_item_t     rx_item_s1;
	logic         result_valid_q;
	result_item_t result_item_q;
	result_item_t core_result;
	logic         out_free;
	logic         proc_en;
	logic         s1_load;

	// Advance stage one unless it holds a last byte while the result register is full and stalled
	assign out_free = !result_valid_q || !result_stall;
	assign proc_en  = rx_valid_s1 && (!rx_item_s1.last_byte || out_free);
	assign s1_load  = !rx_valid_s1 || proc_en;
	assign rx_stall = !s1_load;

	assign result_valid = result_valid_q;
	assign result_item  = result_item_q;

	iphv_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (proc_en),
		.item   (rx_item_s1),
		.result (core_result)
	);

	// Hold the input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (s1_load) begin
			rx_valid_s1 <= rx_valid;
		end
	end

	// Capture the byte transaction
	always_ff @(posedge clk) begin
		if (s1_load && rx_valid) begin
			rx_item_s1 <= rx_item;
		end
	end

	// Hold the result transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= proc_en && rx_item_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && proc_en && rx_item_s1.last_byte) begin
			result_item_q <= core_result;
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the IP header validator: packet stimulus, byte-level predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import iphv_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_PACKET = 131100;

	logic         clk;
	logic         arst_n;
	logic         rx_valid;
	logic         rx_stall;
	rx_item_t     rx_item;
	logic         result_valid;
	logic         result_stall;
	result_item_t result_item;

	// Predictor state for the packet in flight
	logic [16:0] pk_count    = '0;
	logic [7:0]  pk_first    = '0;
	logic [7:0]  pk_hold     = '0;
	logic [16:0] pk_csum     = '0;
	logic [20:0] pk_addr_sum = '0;
	logic [15:0] pk_length   = '0;
	logic        pk_mf       = 1'b0;
	logic [7:0]  pk_proto    = '0;

	result_item_t verdict_q[$];
	result_item_t got_verdict;
	logic [7:0]   pkt[$];
	int           errors      = 0;
	int           cycle_count = 0;
	int           stall_left  = 0;
	bit           calm        = 1'b0;

	ip_header_validator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_item      (rx_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// End the run at the cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 24);
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string name, input logic [20:0] got, input logic [20:0] want);
		if (got !== want)
			report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// Advance the predictor by one accepted byte; give the verdict on the last byte
	task automatic predict_byte(input rx_item_t it, output bit done, output result_item_t v);
		logic [3:0]  ver;
		logic [15:0] word;
		logic [16:0] s;
		logic [16:0] n;
		logic [16:0] body;
		logic [15:0] pay;
		logic [2:0]  st;
		word = '0;
		body = '0;
		pay  = '0;
		if (pk_count == 0)
			pk_first = it.data_byte;
		ver = pk_first[7:4];
		if (pk_count < V6_HDR_LEN) begin
			if (pk_count[0])
				word = {pk_hold, it.data_byte};
			else
				pk_hold = it.data_byte;
			if (ver == VER_V4 && pk_count < V4_HDR_LEN) begin
				// fold the end-around carry on every header word
				if (pk_count[0]) begin
					s = pk_csum + {1'b0, word};
					pk_csum = {1'b0, s[15:0]} + 17'(s[16]);
				end
				if (pk_count == POS_TOT_LEN)
					pk_length = word;
				if (pk_count == POS_FLAGS)
					pk_mf = it.data_byte[MF_BIT];
				if (pk_count == POS_V4_PROTO)
					pk_proto = it.data_byte;
				if (pk_count[0] && pk_count >= POS_V4_ADDR)
					pk_addr_sum = pk_addr_sum + 21'(word);
			end else if (ver == VER_V6) begin
				if (pk_count == POS_V6_PLEN)
					pk_length = word;
				if (pk_count == POS_V6_NEXT)
					pk_proto = it.data_byte;
				if (pk_count[0] && pk_count >= POS_V6_ADDR)
					pk_addr_sum = pk_addr_sum + 21'(word);
			end
		end
		if (pk_count != CNT_MAX)
			pk_count++;
		done = it.last_byte;
		v = '0;
		if (done) begin
			n = pk_count;
			st = ST_OK;
			if (ver == VER_V4) begin
				if (n < V4_HDR_LEN)
					st = ST_SHORT_HEADER;
				else if (pk_first != V4_FIRST)
					st = ST_BAD_IHL;
				else if (pk_csum != {1'b0, CSUM_GOOD})
					st = ST_BAD_CHECKSUM;
				else if (pk_mf)
					st = ST_FRAGMENT;
				else if (pk_length < V4_HDR_LEN16 || n < {1'b0, pk_length})
					st = ST_TRUNCATED;
				else if (pk_proto != PROTO_ICMP && pk_proto != PROTO_UDP)
					st = ST_BAD_PROTOCOL;
				else begin
					pay  = pk_length - V4_HDR_LEN16;
					body = n - {1'b0, pk_length};
				end
			end else if (ver == VER_V6) begin
				if (n < V6_HDR_LEN)
					st = ST_SHORT_HEADER;
				else if (n - V6_HDR_LEN < {1'b0, pk_length})
					st = ST_TRUNCATED;
				else if (pk_proto != PROTO_ICMPV6)
					st = ST_BAD_PROTOCOL;
				else begin
					pay  = pk_length;
					body = n - V6_HDR_LEN - {1'b0, pk_length};
				end
			end else begin
				st = ST_BAD_VERSION;
			end
			v.status     = st;
			v.ip_version = ver;
			v.protocol   = pk_proto;
			if (st == ST_OK) begin
				v.payload_bytes  = pay;
				v.padding_length = body[16] ? 16'hFFFF : body[15:0];
				v.pseudo_sum     = pk_addr_sum + 21'(pk_proto);
			end
			// clear the state for the next packet
			pk_count    = '0;
			pk_first    = '0;
			pk_hold     = '0;
			pk_csum     = '0;
			pk_addr_sum = '0;
			pk_length   = '0;
			pk_mf       = 1'b0;
			pk_proto    = '0;
		end
	endtask

	// Send one byte transaction and record its verdict when it closes a packet
	task automatic send_byte(input rx_item_t it);
		int           gap;
		bit           done;
		result_item_t want;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_item  <= it;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		predict_byte(it, done, want);
		if (done)
			verdict_q.push_back(want);
	endtask

	task automatic send_packet();
		rx_item_t it;
		for (int k = 0; k < pkt.size(); k++) begin
			it.data_byte = pkt[k];
			it.last_byte = (k == pkt.size() - 1);
			send_byte(it);
		end
	endtask

	task automatic push_random(input int count);
		repeat (count)
			pkt.push_back(8'($urandom));
	endtask

	task automatic fill_bytes(input int start, input int count, input logic [7:0] value);
		for (int k = start; k < start + count; k++)
			pkt[k] = value;
	endtask

	// Recompute the IPv4 header checksum so that the header sums to all ones
	task automatic seal_v4();
		logic [16:0] acc;
		acc = '0;
		pkt[10] = 8'h00;
		pkt[11] = 8'h00;
		for (int k = 0; k < 20; k += 2) begin
			acc = acc + {1'b0, pkt[k], pkt[k + 1]};
			acc = {1'b0, acc[15:0]} + 17'(acc[16]);
		end
		pkt[10] = ~acc[15:8];
		pkt[11] = ~acc[7:0];
	endtask

	task automatic set_total(input logic [15:0] total);
		pkt[2] = total[15:8];
		pkt[3] = total[7:0];
		seal_v4();
	endtask

	task automatic build_v4(input int pay, input int pad, input logic [7:0] proto, input bit mf);
		logic [15:0] total;
		logic [7:0]  flags;
		total = 16'(20 + pay);
		flags = 8'($urandom);
		flags[MF_BIT] = mf;
		pkt.delete();
		pkt.push_back(V4_FIRST);
		push_random(1);
		pkt.push_back(total[15:8]);
		pkt.push_back(total[7:0]);
		push_random(2);
		pkt.push_back(flags);
		push_random(2);
		pkt.push_back(proto);
		pkt.push_back(8'h00);
		pkt.push_back(8'h00);
		push_random(8 + pay + pad);
		seal_v4();
	endtask

	task automatic build_v6(input int pay, input int pad, input logic [7:0] next_hdr);
		logic [15:0] plen;
		plen = 16'(pay);
		pkt.delete();
		pkt.push_back({VER_V6, 4'($urandom)});
		push_random(3);
		pkt.push_back(plen[15:8]);
		pkt.push_back(plen[7:0]);
		pkt.push_back(next_hdr);
		push_random(33 + pay + pad);
	endtask

	// Stall the result side in random stretches; no new stretch starts while calm
	always @(posedge clk) begin
		if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
			stall_left = pick_gap();
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Check each accepted result against the oldest pending verdict
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (verdict_q.size() == 0) begin
				report("result with no packet pending");
			end else begin
				got_verdict = verdict_q.pop_front();
				check_field("status", 21'(result_item.status), 21'(got_verdict.status));
				check_field("ip_version", 21'(result_item.ip_version),
					21'(got_verdict.ip_version));
				check_field("protocol", 21'(result_item.protocol), 21'(got_verdict.protocol));
				check_field("payload_bytes", 21'(result_item.payload_bytes),
					21'(got_verdict.payload_bytes));
				check_field("padding_length", 21'(result_item.padding_length),
					21'(got_verdict.padding_length));
				check_field("pseudo_sum", result_item.pseudo_sum, got_verdict.pseudo_sum);
			end
		end
	end

	// IPv4: good packets and each failure, the short header last
	task automatic test_ipv4();
		// all-ones addresses give the largest pseudo sum
		build_v4(8, 0, PROTO_UDP, 1'b0);
		fill_bytes(12, 8, 8'hFF);
		seal_v4();
		send_packet();
		// ICMP still reports a pseudo sum; zero addresses, trailing padding
		build_v4(0, 3, PROTO_ICMP, 1'b0);
		fill_bytes(12, 8, 8'h00);
		seal_v4();
		send_packet();
		build_v4(4, 0, PROTO_UDP, 1'b0);
		pkt[0] = 8'h46;
		seal_v4();
		send_packet();
		build_v4(4, 0, PROTO_UDP, 1'b0);
		pkt[11] = pkt[11] ^ 8'h01;
		send_packet();
		build_v4(4, 0, PROTO_UDP, 1'b1);
		send_packet();
		// declared length far past the received bytes
		build_v4(4, 0, PROTO_UDP, 1'b0);
		set_total(16'hFFFF);
		send_packet();
		// declared length below the header size
		build_v4(4, 0, PROTO_UDP, 1'b0);
		set_total(16'd10);
		send_packet();
		build_v4(2, 1, 8'd6, 1'b0);
		send_packet();
		// cut inside the header
		build_v4(0, 0, PROTO_UDP, 1'b0);
		while (pkt.size() > 12)
			void'(pkt.pop_back());
		send_packet();
	endtask

	// IPv6: good packets, short header, missing payload, wrong next header
	task automatic test_ipv6();
		build_v6(6, 0, PROTO_ICMPV6);
		fill_bytes(8, 32, 8'hFF);
		send_packet();
		build_v6(0, 5, PROTO_ICMPV6);
		send_packet();
		build_v6(0, 0, PROTO_ICMPV6);
		while (pkt.size() > 30)
			void'(pkt.pop_back());
		send_packet();
		build_v6(10, 0, PROTO_ICMPV6);
		pkt[4] = 8'h00;
		pkt[5] = 8'd100;
		send_packet();
		build_v6(4, 2, PROTO_UDP);
		send_packet();
	endtask

	// One-byte packets and unknown versions
	task automatic test_odd_packets();
		pkt.delete();
		pkt.push_back(V4_FIRST);
		send_packet();
		pkt.delete();
		pkt.push_back(8'h6F);
		send_packet();
		pkt.delete();
		pkt.push_back(8'h00);
		send_packet();
		pkt.delete();
		pkt.push_back(8'hFF);
		send_packet();
		pkt.delete();
		pkt.push_back(8'h7A);
		push_random(20);
		send_packet();
	endtask

	// Padding long enough to saturate the byte counter and the padding length
	task automatic test_long_packet();
		calm = 1'b1;
		build_v4(0, LONG_PACKET - 20, PROTO_UDP, 1'b0);
		send_packet();
		calm = 1'b0;
	endtask

	// Mostly well-formed packets with random content, some damaged, some noise
	task automatic test_random();
		int          sent_bytes;
		int          packets;
		int          r;
		int          idx;
		int          cut;
		int          pad;
		logic [7:0]  proto;
		sent_bytes = 0;
		packets    = 0;
		while (sent_bytes < 950 || packets < 48) begin
			calm  = ($urandom_range(0, 9) == 0);
			r     = $urandom_range(0, 99);
			pad   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
			idx   = $urandom_range(0, 9);
			if (r < 40) begin
				proto = (idx < 4) ? PROTO_UDP : (idx < 8) ? PROTO_ICMP : 8'($urandom);
				build_v4($urandom_range(0, 16), pad, proto, $urandom_range(0, 9) == 0);
			end else if (r < 75) begin
				proto = (idx < 8) ? PROTO_ICMPV6 : 8'($urandom);
				build_v6($urandom_range(0, 16), pad, proto);
			end else begin
				pkt.delete();
				push_random($urandom_range(1, 24));
				if ($urandom_range(0, 1))
					pkt[0][7:4] = $urandom_range(0, 1) ? VER_V4 : VER_V6;
			end
			// damage a well-formed packet now and then
			if (r < 75 && $urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 1)) begin
					idx = $urandom_range(0, pkt.size() - 1);
					pkt[idx] = pkt[idx] ^ 8'(1 << $urandom_range(0, 7));
				end else begin
					cut = $urandom_range(1, pkt.size() - 1);
					repeat (cut)
						void'(pkt.pop_back());
				end
			end
			sent_bytes += pkt.size();
			packets++;
			send_packet();
		end
		calm = 1'b0;
	endtask

	// Reset, run the tests, drain, and judge
	initial begin
		rx_valid     <= 1'b0;
		rx_item      <= '0;
		result_stall <= 1'b0;
		arst_n       <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ipv4();
		test_ipv6();
		test_odd_packets();
		test_long_packet();
		test_random();
		rx_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
